// ===== design/two_class_fifo_oldest_first_unit_macros.svh =====
// Assertion macros for the two-class oldest-first queue unit.
// Used by the checker file; depends on nothing else.
`ifndef TWO_CLASS_FIFO_OLDEST_FIRST_UNIT_MACROS_SVH
`define TWO_CLASS_FIFO_OLDEST_FIRST_UNIT_MACROS_SVH

// Checked only outside reset.
`define TCFO_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked during reset as well.
`define TCFO_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/tcfo_pkg.sv =====
// Shared constants of the two-class oldest-first queue unit: command and status codes
// and the stamp width. No dependencies.
package tcfo_pkg;

  localparam int STAMP_BITS = 6;

  localparam logic [2:0] CMD_ENQ0    = 3'd0;
  localparam logic [2:0] CMD_ENQ1    = 3'd1;
  localparam logic [2:0] CMD_DEQ0    = 3'd2;
  localparam logic [2:0] CMD_DEQ1    = 3'd3;
  localparam logic [2:0] CMD_DEQ_ANY = 3'd4;

  localparam logic [2:0] ST_ENQ        = 3'd0;
  localparam logic [2:0] ST_DEQ        = 3'd1;
  localparam logic [2:0] ST_EMPTY0     = 3'd2;
  localparam logic [2:0] ST_EMPTY1     = 3'd3;
  localparam logic [2:0] ST_EMPTY_BOTH = 3'd4;
  localparam logic [2:0] ST_FULL       = 3'd5;

endpackage

// ===== design/two_class_fifo_oldest_first_unit.sv =====
// Top level of the two-class oldest-first queue unit: two FIFOs sharing an arrival stamp.
// Depends on tcfo_pkg.
//
// Usage:
// The command channel (in_valid, in_ready, command, item_tag) carries one command per
// transfer: enqueue into class 0 or class 1, dequeue from class 0 or class 1, or dequeue
// the older head of the two classes. Each command yields exactly one result on the
// result channel (out_valid, out_ready, status, out_tag, out_class).
// The result is registered and valid in the cycle after the command transfer. Throughput
// is one command per cycle while results are taken, set by the single result register;
// each FIFO memory has one write port and one registered read port that tracks its head.
// Enqueue into a full class is refused with the full status; dequeue from an empty
// class reports the matching empty status. Stamps are 6 bits and wrap; age is decided
// by their modular difference.
// Reset clears heads, tails, counts, the arrival counter and the result valid flag;
// memory contents are left as they are and no clearing pass is needed.
// When the receiver stalls, the result register holds and in_ready drops, so at most
// one result is ever waiting; a new command is taken in the cycle the result leaves.
module two_class_fifo_oldest_first_unit #(
  parameter int QUEUE_DEPTH = 16,
  parameter int TAG_BITS    = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [2:0]          command,
  input  logic [TAG_BITS-1:0] item_tag,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [2:0]          status,
  output logic [TAG_BITS-1:0] out_tag,
  output logic                out_class
);
  import tcfo_pkg::*;

  localparam int PTR_W   = $clog2(QUEUE_DEPTH);
  localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int ENTRY_W = TAG_BITS + STAMP_BITS;
  localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(QUEUE_DEPTH);

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    bump = (p == LAST_PTR) ? '0 : p + PTR_W'(1);
  endfunction

  logic [ENTRY_W-1:0] mem0 [QUEUE_DEPTH];
  logic [ENTRY_W-1:0] mem1 [QUEUE_DEPTH];

  logic [PTR_W-1:0] head0, tail0, head1, tail1;
  logic [PTR_W-1:0] head0_next, tail0_next, head1_next, tail1_next;
  logic [CNT_W-1:0] count0, count1, count0_next, count1_next;
  logic [STAMP_BITS-1:0] counter, counter_next;
  logic [ENTRY_W-1:0] head_entry0, head_entry1, wr_entry;

  logic accept;
  logic enq0, enq1, deq0, deq1;
  logic do_enq0, do_enq1, do_deq0, do_deq1;
  logic [STAMP_BITS-1:0] stamp_diff;
  logic pick0;
  logic [2:0] res_status;
  logic [TAG_BITS-1:0] res_tag;
  logic res_class;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign wr_entry = {item_tag, counter};

  assign stamp_diff = head_entry1[STAMP_BITS-1:0] - head_entry0[STAMP_BITS-1:0];
  assign pick0 = (stamp_diff != '0) && !stamp_diff[STAMP_BITS-1];

  always_comb begin
    enq0       = 1'b0;
    enq1       = 1'b0;
    deq0       = 1'b0;
    deq1       = 1'b0;
    res_status = ST_FULL;
    res_tag    = '0;
    res_class  = 1'b0;
    case (command)
      CMD_ENQ0: begin
        if (count0 != FULL_CNT) begin
          enq0       = 1'b1;
          res_status = ST_ENQ;
        end
      end
      CMD_ENQ1: begin
        if (count1 != FULL_CNT) begin
          enq1       = 1'b1;
          res_status = ST_ENQ;
        end
      end
      CMD_DEQ0: begin
        if (count0 == '0) res_status = ST_EMPTY0;
        else deq0 = 1'b1;
      end
      CMD_DEQ1: begin
        if (count1 == '0) res_status = ST_EMPTY1;
        else deq1 = 1'b1;
      end
      CMD_DEQ_ANY: begin
        if (count0 == '0 && count1 == '0) res_status = ST_EMPTY_BOTH;
        else if (count1 == '0) deq0 = 1'b1;
        else if (count0 == '0) deq1 = 1'b1;
        else if (pick0) deq0 = 1'b1;
        else deq1 = 1'b1;
      end
      default: begin
        res_status = ST_FULL;
      end
    endcase
    if (deq0) begin
      res_status = ST_DEQ;
      res_tag    = head_entry0[ENTRY_W-1:STAMP_BITS];
    end else if (deq1) begin
      res_status = ST_DEQ;
      res_tag    = head_entry1[ENTRY_W-1:STAMP_BITS];
      res_class  = 1'b1;
    end
  end

  assign do_enq0 = accept && enq0;
  assign do_enq1 = accept && enq1;
  assign do_deq0 = accept && deq0;
  assign do_deq1 = accept && deq1;

  always_comb begin
    head0_next   = do_deq0 ? bump(head0) : head0;
    head1_next   = do_deq1 ? bump(head1) : head1;
    tail0_next   = do_enq0 ? bump(tail0) : tail0;
    tail1_next   = do_enq1 ? bump(tail1) : tail1;
    count0_next  = count0;
    count1_next  = count1;
    if (do_enq0) count0_next = count0 + CNT_W'(1);
    else if (do_deq0) count0_next = count0 - CNT_W'(1);
    if (do_enq1) count1_next = count1 + CNT_W'(1);
    else if (do_deq1) count1_next = count1 - CNT_W'(1);
    counter_next = (do_enq0 || do_enq1) ? counter + STAMP_BITS'(1) : counter;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head0   <= '0;
      tail0   <= '0;
      count0  <= '0;
      head1   <= '0;
      tail1   <= '0;
      count1  <= '0;
      counter <= '0;
    end else begin
      head0   <= head0_next;
      tail0   <= tail0_next;
      count0  <= count0_next;
      head1   <= head1_next;
      tail1   <= tail1_next;
      count1  <= count1_next;
      counter <= counter_next;
    end
  end

  // The head entry register follows the next head, with the write forwarded when an
  // enqueue lands on that very slot.
  always_ff @(posedge clk) begin
    if (do_enq0) mem0[tail0] <= wr_entry;
    if (do_enq0 && tail0 == head0_next) head_entry0 <= wr_entry;
    else head_entry0 <= mem0[head0_next];
  end

  always_ff @(posedge clk) begin
    if (do_enq1) mem1[tail1] <= wr_entry;
    if (do_enq1 && tail1 == head1_next) head_entry1 <= wr_entry;
    else head_entry1 <= mem1[head1_next];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status    <= res_status;
      out_tag   <= res_tag;
      out_class <= res_class;
    end
  end

endmodule

// ===== design/tcfo_checker.sv =====
// Port-level checker for the two-class oldest-first queue unit, with its bind statement.
// Depends on tcfo_pkg and two_class_fifo_oldest_first_unit_macros.svh.
`include "two_class_fifo_oldest_first_unit_macros.svh"

module tcfo_checker #(
  parameter int TAG_BITS = 16
) (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic [2:0]          command,
  input logic                out_valid,
  input logic                out_ready,
  input logic [2:0]          status,
  input logic [TAG_BITS-1:0] out_tag,
  input logic                out_class
);
  import tcfo_pkg::*;

  `TCFO_ASSERT(a_result_held, out_valid && !out_ready |=> out_valid && $stable(status) && $stable(out_tag) && $stable(out_class), "Stalled result changed.")
  `TCFO_ASSERT(a_idle_fields, out_valid && status != ST_DEQ |-> out_tag == '0 && !out_class, "Tag or class set without a dequeue.")
  `TCFO_ASSERT(a_status_range, out_valid |-> status <= ST_FULL, "Status code out of range.")
  `TCFO_ASSERT(a_bad_command, in_valid && in_ready && command > CMD_DEQ_ANY |=> out_valid && status == ST_FULL, "Unused command did not report refusal.")
  `TCFO_ASSERT_RST(a_reset_empty, rst |=> !out_valid, "Result valid after reset.")

endmodule

bind two_class_fifo_oldest_first_unit tcfo_checker #(.TAG_BITS(TAG_BITS)) u_tcfo_checker (.*);
